@@ rtl/core/ckbc_pkg.sv @@
// shared types and constants for the counter keystream byte cipher
package ckbc_pkg;

    localparam int unsigned HALF_DEPTH = 256;
    localparam int unsigned ADDR_W     = $clog2(HALF_DEPTH);
    localparam int unsigned KEY_W      = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CNT_W      = 2 * ADDR_W;

    localparam logic [KEY_W-1:0]  KEY_ONE_RESET = 32'h9dfa_0f13;
    localparam logic [KEY_W-1:0]  KEY_TWO_RESET = 32'h62a4_796d;
    localparam logic [BYTE_W-1:0] PRE_XOR       = 8'hAB;

    typedef enum logic [1:0] {
        OP_ENCRYPT = 2'd0,
        OP_DECRYPT = 2'd1,
        OP_REGEN   = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [0:0] {
        REG_KEY_ONE = 1'b0,
        REG_KEY_TWO = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        GEN_IDLE,
        GEN_MUL,
        GEN_ADD
    } t_gen_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

endpackage

@@ rtl/core/counter_keystream_byte_cipher.sv @@
// path: request and table read registered in stage one, result in the output register
// throughput: one encrypt or decrypt byte per cycle while no fill runs and the output is not stalled
// regenerate: input held off while each table half's fill sequencer writes its 256
// entries, each step a GEN_MUL then a GEN_ADD state for the chained 8-bit multiplies
// reset: keys to defaults, both counters to zero; table output is masked to zero until the
// first regenerate, no clearing pass
module counter_keystream_byte_cipher
    import ckbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // tdata: data_byte[7:0]
    input  logic [BYTE_W-1:0] i_s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]        i_s_axis_tuser,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // tdata: out_byte[7:0]
    output logic [BYTE_W-1:0] o_m_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [0:0]        i_cfg_index,
    input  logic [KEY_W-1:0]  i_cfg_data
);

    logic [KEY_W-1:0]  r_key_one;
    logic [KEY_W-1:0]  r_key_two;
    logic [CNT_W-1:0]  r_enc_cnt;
    logic [CNT_W-1:0]  r_dec_cnt;
    logic              r_table_valid;
    logic              r_s1_valid;
    t_opcode           r_s1_op;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;

    t_opcode           w_op;
    logic              w_accept;
    logic              w_adv;
    logic              w_busy;
    logic              w_start;
    logic              w_is_xform;
    logic [CNT_W-1:0]  w_cnt;
    t_rd_req           w_rd_lo;
    t_rd_req           w_rd_hi;
    logic [BYTE_W-1:0] w_lo_data;
    logic [BYTE_W-1:0] w_hi_data;
    logic              w_lo_busy;
    logic              w_hi_busy;
    logic [BYTE_W-1:0] w_pre;
    logic [BYTE_W-1:0] w_result;

    assign w_op       = t_opcode'(i_s_axis_tuser);
    assign w_busy     = w_lo_busy | w_hi_busy;
    assign w_adv      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !w_busy && (!r_s1_valid || w_adv);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_xform = (w_op == OP_ENCRYPT) || (w_op == OP_DECRYPT);
    assign w_start    = w_accept && (w_op == OP_REGEN);
    assign w_cnt      = (w_op == OP_DECRYPT) ? r_dec_cnt : r_enc_cnt;

    assign w_rd_lo.en   = w_accept && w_is_xform;
    assign w_rd_lo.addr = w_cnt[ADDR_W-1:0];
    assign w_rd_hi.en   = w_accept && w_is_xform;
    assign w_rd_hi.addr = w_cnt[CNT_W-1:ADDR_W];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_one <= KEY_ONE_RESET;
            r_key_two <= KEY_TWO_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_KEY_ONE: r_key_one <= i_cfg_data;
                REG_KEY_TWO: r_key_two <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc_cnt     <= '0;
            r_dec_cnt     <= '0;
            r_table_valid <= 1'b0;
        end else begin
            if (w_accept && (w_op == OP_ENCRYPT)) begin
                r_enc_cnt <= r_enc_cnt + 1'b1;
            end
            if (w_accept && (w_op == OP_DECRYPT)) begin
                r_dec_cnt <= r_dec_cnt + 1'b1;
            end
            // every entry gets written by the fill, so one flag covers the whole table
            if (w_start) begin
                r_table_valid <= 1'b1;
            end
        end
    end

    ckbc_half u_half_lo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_key     (r_key_one),
        .i_rd      (w_rd_lo),
        .o_rd_data (w_lo_data),
        .o_busy    (w_lo_busy)
    );

    ckbc_half u_half_hi (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_key     (r_key_two),
        .i_rd      (w_rd_hi),
        .o_rd_data (w_hi_data),
        .o_busy    (w_hi_busy)
    );

    // stage one: request waits here while the table read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op   <= w_op;
            r_s1_byte <= i_s_axis_tdata;
        end
    end

    always_comb begin
        w_pre = r_s1_byte ^ PRE_XOR;
        unique case (r_s1_op)
            OP_ENCRYPT, OP_DECRYPT: begin
                w_result = {w_pre[3:0], w_pre[7:4]};
                if (r_table_valid) begin
                    w_result = w_result ^ w_lo_data ^ w_hi_data;
                end
            end
            default: begin
                w_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_out_data <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

@@ rtl/core/ckbc_half.sv @@
// one keystream table half: 256 x 8 memory with its fill sequencer
module ckbc_half
    import ckbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [KEY_W-1:0]  i_key,
    input  t_rd_req           i_rd,
    output logic [BYTE_W-1:0] o_rd_data,
    output logic              o_busy
);

    logic [BYTE_W-1:0] mem [HALF_DEPTH];

    t_gen_state        r_state, n_state;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [BYTE_W-1:0] r_x, n_x;
    logic [BYTE_W-1:0] r_t, n_t;
    logic [BYTE_W-1:0] r_rd_data;
    logic              w_wr_en;
    logic [2*BYTE_W-1:0] w_prod_k2;
    logic [2*BYTE_W-1:0] w_prod_t;

    // the two multiplies of one step sit in separate cycles
    assign w_prod_k2 = (2*BYTE_W)'(r_x) * (2*BYTE_W)'(i_key[23:16]);
    assign w_prod_t  = (2*BYTE_W)'(r_t) * (2*BYTE_W)'(r_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GEN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_x   <= n_x;
        r_t   <= n_t;
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_x     = r_x;
        n_t     = r_t;
        w_wr_en = 1'b0;
        unique case (r_state)
            GEN_IDLE: begin
                if (i_start) begin
                    n_state = GEN_MUL;
                    n_idx   = '0;
                    n_x     = i_key[31:24];
                end
            end
            GEN_MUL: begin
                // store x, then start advancing it
                w_wr_en = 1'b1;
                n_t     = i_key[15:8] + w_prod_k2[BYTE_W-1:0];
                n_state = GEN_ADD;
            end
            GEN_ADD: begin
                n_x   = w_prod_t[BYTE_W-1:0] + i_key[7:0];
                n_idx = r_idx + 1'b1;
                if (r_idx == ADDR_W'(HALF_DEPTH - 1)) begin
                    n_state = GEN_IDLE;
                end else begin
                    n_state = GEN_MUL;
                end
            end
            default: begin
                n_state = GEN_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_idx] <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = (r_state != GEN_IDLE);

endmodule

@@ rtl/core/ckbc_checker.sv @@
// port-level checks for the cipher top level, bound in below
module ckbc_checker
    import ckbc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic [BYTE_W-1:0] i_s_axis_tdata,
    input logic [1:0]        i_s_axis_tuser,
    input logic              i_s_axis_tvalid,
    input logic              o_s_axis_tready,
    input logic [BYTE_W-1:0] o_m_axis_tdata,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready
);

    logic w_in_req;
    logic w_regen_req;

    assign w_in_req    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_regen_req = w_in_req && (t_opcode'(i_s_axis_tuser) == OP_REGEN);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // every request finds the output valid once it has passed stage one and the output register
    a_result_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_req |-> ##2 o_m_axis_tvalid)
        else $error("no result two cycles after request");

    // the input stays closed as a table fill starts
    a_regen_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_regen_req |=> !o_s_axis_tready ##1 !o_s_axis_tready)
        else $error("input reopened during table fill");

    // the input never opens while the fill has just begun
    a_no_accept_after_regen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_regen_req |=> !w_in_req)
        else $error("request taken right after regenerate");

endmodule

bind counter_keystream_byte_cipher ckbc_checker u_ckbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

@@ bench/tb.sv @@
// self-checking bench for the counter keystream byte cipher
`timescale 1ns / 1ps

module tb;
    import ckbc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned PHASE_ITEMS    = 210;
    localparam int unsigned NUM_PHASES     = 8;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned DIR_ROWS       = 20;

    typedef struct packed {
        t_opcode     op;
        logic [7:0]  data;
        logic        known;
        logic [7:0]  result;
    } t_dir_row;

    // before the first regenerate the cipher output is just the nibble swap of data ^ 0xab
    localparam t_dir_row DIRECTED_ROWS [DIR_ROWS] = '{
        '{OP_ENCRYPT, 8'h00, 1'b1, 8'hBA},
        '{OP_ENCRYPT, 8'hFF, 1'b1, 8'h45},
        '{OP_ENCRYPT, 8'h5A, 1'b1, 8'h1F},
        '{OP_DECRYPT, 8'h00, 1'b1, 8'hBA},
        '{OP_DECRYPT, 8'hFF, 1'b1, 8'h45},
        '{OP_DECRYPT, 8'hA5, 1'b1, 8'hE0},
        '{OP_NONE,    8'h00, 1'b1, 8'h00},
        '{OP_NONE,    8'hFF, 1'b1, 8'h00},
        '{OP_REGEN,   8'h00, 1'b1, 8'h00},
        '{OP_REGEN,   8'hFF, 1'b1, 8'h00},
        '{OP_ENCRYPT, 8'h00, 1'b0, 8'h00},
        '{OP_ENCRYPT, 8'hFF, 1'b0, 8'h00},
        '{OP_DECRYPT, 8'h00, 1'b0, 8'h00},
        '{OP_DECRYPT, 8'hFF, 1'b0, 8'h00},
        '{OP_NONE,    8'h3C, 1'b1, 8'h00},
        '{OP_ENCRYPT, 8'h3C, 1'b0, 8'h00},
        '{OP_DECRYPT, 8'h3C, 1'b0, 8'h00},
        '{OP_ENCRYPT, 8'hAB, 1'b0, 8'h00},
        '{OP_DECRYPT, 8'h0F, 1'b0, 8'h00},
        '{OP_ENCRYPT, 8'hF0, 1'b0, 8'h00}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic [BYTE_W-1:0] s_tdata;
    logic [1:0]        s_tuser;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [0:0]        cfg_index;
    logic [KEY_W-1:0]  cfg_data;

    // predictor state
    logic [7:0]       keystream [2*HALF_DEPTH];
    logic [15:0]      enc_count;
    logic [15:0]      dec_count;
    logic [KEY_W-1:0] cur_key [2];

    logic [7:0]  expected_bytes [$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned stall_cycles = 0;
    int unsigned burst_left;
    int unsigned max_gap;
    bit          long_hold_done = 1'b0;

    counter_keystream_byte_cipher uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void fill_keystream_half(logic [KEY_W-1:0] key, int unsigned base);
        logic [7:0] x;
        x = key[31:24];
        for (int i = 0; i < HALF_DEPTH; i++) begin
            keystream[base + i] = x;
            x = (key[15:8] + x * key[23:16]) * x + key[7:0];
        end
    endfunction

    function automatic logic [7:0] cipher_predict(t_opcode op, logic [7:0] b);
        logic [7:0]  v;
        logic [15:0] cnt;
        v = 8'h00;
        case (op)
            OP_ENCRYPT, OP_DECRYPT: begin
                cnt = (op == OP_ENCRYPT) ? enc_count : dec_count;
                v = b ^ PRE_XOR;
                v = {v[3:0], v[7:4]} ^ keystream[cnt[7:0]] ^ keystream[HALF_DEPTH + cnt[15:8]];
                if (op == OP_ENCRYPT) begin
                    enc_count = cnt + 16'd1;
                end else begin
                    dec_count = cnt + 16'd1;
                end
            end
            OP_REGEN: begin
                fill_keystream_half(cur_key[REG_KEY_ONE], 0);
                fill_keystream_half(cur_key[REG_KEY_TWO], HALF_DEPTH);
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_item(t_opcode op, logic [7:0] b, logic known, logic [7:0] fixed);
        int unsigned gap;
        logic [7:0]  want;
        if (burst_left == 0) begin
            gap = $urandom_range(0, max_gap);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
        want = cipher_predict(op, b);
        expected_bytes.push_back(known ? fixed : want);
    endtask

    task automatic send_random(bit cipher_only);
        int unsigned r;
        t_opcode     op;
        r = $urandom_range(0, 199);
        if (cipher_only)
            op = (r == 0) ? OP_NONE : (r < 100) ? OP_ENCRYPT : OP_DECRYPT;
        else
            op = (r < 92) ? OP_ENCRYPT : (r < 184) ? OP_DECRYPT :
                 (r < 192) ? OP_REGEN : OP_NONE;
        send_item(op, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
    endtask

    // sender pauses until every result is back and any table fill has finished
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic write_keys(logic [KEY_W-1:0] k1, logic [KEY_W-1:0] k2);
        cfg_valid <= 1'b1;
        cfg_index <= REG_KEY_ONE;
        cfg_data  <= k1;
        do @(posedge i_clk); while (!cfg_ready);
        cur_key[REG_KEY_ONE] = k1;
        cfg_index <= REG_KEY_TWO;
        cfg_data  <= k2;
        do @(posedge i_clk); while (!cfg_ready);
        cur_key[REG_KEY_TWO] = k2;
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected %02h, got %02h", $realtime, what, want, got);
    endtask

    // result checker
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (expected_bytes.size() == 0) begin
                report_mismatch("out_byte with no request pending", 8'h00, m_tdata);
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want) report_mismatch("out_byte", want, m_tdata);
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // output back-pressure: rotating patterns plus one long hold-off
    initial begin
        int unsigned tick;
        tick = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (!long_hold_done && results_seen >= 400) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                case ((tick >> 8) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (tick % 7) != 0;
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] k1_list [NUM_PHASES];
        logic [KEY_W-1:0] k2_list [NUM_PHASES];
        t_dir_row         row;

        burst_left     = 0;
        max_gap        = 8;
        enc_count      = 16'd0;
        dec_count      = 16'd0;
        cur_key[REG_KEY_ONE] = KEY_ONE_RESET;
        cur_key[REG_KEY_TWO] = KEY_TWO_RESET;
        foreach (keystream[i]) keystream[i] = 8'h00;

        k1_list = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                    KEY_ONE_RESET, $urandom, $urandom, $urandom};
        k2_list = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                    KEY_TWO_RESET, $urandom, $urandom, $urandom};

        i_rst_n   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_ENCRYPT;
        cfg_valid <= 1'b0;
        cfg_index <= REG_KEY_ONE;
        cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIRECTED_ROWS[i];
            send_item(row.op, row.data, row.known, row.result);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_keys(k1_list[p], k2_list[p]);
            repeat (PHASE_ITEMS) send_random(1'b0);
        end

        // closing cipher run with short gaps on a fresh table
        drain_results();
        write_keys($urandom, $urandom);
        send_item(OP_REGEN, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
        max_gap = 2;
        repeat (PHASE_ITEMS / 4) send_random(1'b1);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

@@ counter_keystream_byte_cipher.f @@
rtl/core/ckbc_pkg.sv
rtl/core/ckbc_half.sv
rtl/core/counter_keystream_byte_cipher.sv
rtl/core/ckbc_checker.sv
bench/tb.sv
